// File: sv/spe_pkg.sv
// Shared types, constants and clamp helpers for the sparse polynomial evaluator.
`timescale 1ns / 1ps
package spe_pkg;

    localparam int MAX_TERMS = 16;
    localparam int CNT_W     = $clog2(MAX_TERMS + 1);
    localparam int IDX_W     = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
    localparam int TOTAL_W   = 5;
    localparam int COEF_W    = 16;
    localparam int EXP_W     = 5;
    localparam int VAL_W     = 32;
    localparam int PROD_W    = VAL_W + COEF_W;
    localparam int WIDE_W    = PROD_W - 8 + 1;

    localparam logic [VAL_W-1:0] Q_ONE = VAL_W'(32'h0001_0000);

    localparam logic REQ_APPEND = 1'b0;
    localparam logic REQ_EVAL   = 1'b1;

    localparam logic [1:0] ST_DONE = 2'd0;
    localparam logic [1:0] ST_DROP = 2'd1;
    localparam logic [1:0] ST_SAT  = 2'd2;

    typedef struct packed {
        logic                     req_type;
        logic signed [COEF_W-1:0] coefficient;
        logic [EXP_W-1:0]         exponent;
        logic signed [COEF_W-1:0] x_value;
    } t_spe_req;

    typedef struct packed {
        logic signed [VAL_W-1:0] value;
        logic [1:0]              status;
        logic [TOTAL_W-1:0]      term_total;
    } t_spe_rsp;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_LOAD,
        S_MUL,
        S_PWR,
        S_TERM,
        S_ACC,
        S_DONE
    } t_spe_state;

    // True when v lies outside the signed 32-bit range.
    function automatic logic spe_ovf(input logic signed [WIDE_W-1:0] v);
        logic signed [WIDE_W-1:0] hi;
        logic signed [WIDE_W-1:0] lo;
        hi = WIDE_W'(64'sh7FFF_FFFF);
        lo = -hi - WIDE_W'(1);
        return (v > hi) || (v < lo);
    endfunction

    // Clamp v to the signed 32-bit range.
    function automatic logic signed [VAL_W-1:0] spe_clamp(
        input logic signed [WIDE_W-1:0] v
    );
        logic signed [WIDE_W-1:0] hi;
        logic signed [WIDE_W-1:0] lo;
        hi = WIDE_W'(64'sh7FFF_FFFF);
        lo = -hi - WIDE_W'(1);
        if (v > hi) begin
            return {1'b0, {(VAL_W-1){1'b1}}};
        end else if (v < lo) begin
            return {1'b1, {(VAL_W-1){1'b0}}};
        end else begin
            return v[VAL_W-1:0];
        end
    endfunction

endpackage

// File: sv/sparse_polynomial_eval.sv
// Sparse polynomial evaluator: term table plus a sequenced shared multiplier.
// An append gives its result in the cycle after the transfer.
// An evaluate walks the stored terms in turn (read, load, power steps, coefficient product,
// accumulate); one 32x16 multiplier serves every power step and coefficient product.
// A new request is taken only after the last result; busy stays high through the result cycle.
// Reset (synchronous, active low) empties the table and returns to idle; the receiver
// cannot stall, each result is shown for exactly one cycle with o_valid high.
`timescale 1ns / 1ps
module sparse_polynomial_eval (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  spe_pkg::t_spe_req i_req,
    output logic              o_valid,
    output spe_pkg::t_spe_rsp o_rsp
);
    import spe_pkg::*;

    // Term table: one write port (append), one registered read port (walk).
    logic signed [COEF_W-1:0] r_coef_mem [MAX_TERMS];
    logic [EXP_W-1:0]         r_exp_mem  [MAX_TERMS];
    logic signed [COEF_W-1:0] r_rd_coef;
    logic [EXP_W-1:0]         r_rd_exp;

    t_spe_state r_state, n_state;

    logic [CNT_W-1:0]         r_count;
    logic [IDX_W-1:0]         r_idx;
    logic [EXP_W-1:0]         r_exp_left;
    logic signed [COEF_W-1:0] r_x;
    logic signed [VAL_W-1:0]  r_power;
    logic signed [VAL_W-1:0]  r_term;
    logic signed [VAL_W-1:0]  r_sum;
    logic signed [PROD_W-1:0] r_prod;
    logic                     r_sat;
    logic signed [VAL_W-1:0]  r_value;
    logic [1:0]               r_status;

    logic                     w_accept;
    logic                     w_full;
    logic                     w_last;
    logic signed [COEF_W-1:0] w_mul_b;
    logic signed [PROD_W-1:0] w_prod;
    logic signed [WIDE_W-1:0] w_scaled;
    logic signed [WIDE_W-1:0] w_sum_wide;
    logic [CNT_W-1:0]         w_idx_next;
    logic [CNT_W+TOTAL_W-1:0] w_total_ext;

    assign w_accept   = start && !busy;
    assign w_full     = (r_count == CNT_W'(MAX_TERMS));
    assign w_idx_next = CNT_W'(r_idx) + CNT_W'(1);
    assign w_last     = (w_idx_next == r_count);

    // Shared unit: power times x while exponent steps remain, else power times coefficient.
    assign w_mul_b  = (r_exp_left != '0) ? r_x : r_rd_coef;
    assign w_prod   = PROD_W'(r_power) * PROD_W'(w_mul_b);
    // Arithmetic shift is a floor divide by 256.
    assign w_scaled = WIDE_W'(r_prod >>> 8);
    assign w_sum_wide = WIDE_W'(r_sum) + WIDE_W'(r_term);

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_req.req_type == REQ_EVAL && r_count != '0) begin
                        n_state = S_READ;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_READ: n_state = S_LOAD;
            S_LOAD: n_state = S_MUL;
            S_MUL: begin
                n_state = (r_exp_left != '0) ? S_PWR : S_TERM;
            end
            S_PWR:  n_state = S_MUL;
            S_TERM: n_state = S_ACC;
            S_ACC:  n_state = w_last ? S_DONE : S_READ;
            S_DONE: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Handshake outputs
    always_comb begin
        busy    = (r_state != S_IDLE);
        o_valid = (r_state == S_DONE);
    end

    assign w_total_ext      = {TOTAL_W'(0), r_count};
    assign o_rsp.value      = r_value;
    assign o_rsp.status     = r_status;
    assign o_rsp.term_total = w_total_ext[TOTAL_W-1:0];

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_IDLE && w_accept && i_req.req_type == REQ_APPEND && !w_full) begin
                r_count <= r_count + CNT_W'(1);
            end
        end
    end

    // Term table write and registered read
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && w_accept && i_req.req_type == REQ_APPEND && !w_full) begin
            r_coef_mem[r_count[IDX_W-1:0]] <= i_req.coefficient;
            r_exp_mem[r_count[IDX_W-1:0]]  <= i_req.exponent;
        end
        r_rd_coef <= r_coef_mem[r_idx];
        r_rd_exp  <= r_exp_mem[r_idx];
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    // Start the walk clean; append and empty table both report zero.
                    r_x     <= i_req.x_value;
                    r_idx   <= '0;
                    r_sum   <= '0;
                    r_sat   <= 1'b0;
                    r_value <= '0;
                    if (i_req.req_type == REQ_APPEND && w_full) begin
                        r_status <= ST_DROP;
                    end else begin
                        r_status <= ST_DONE;
                    end
                end
            end
            S_LOAD: begin
                r_power    <= Q_ONE;
                r_exp_left <= r_rd_exp;
            end
            S_MUL: begin
                r_prod <= w_prod;
            end
            S_PWR: begin
                // Hold a clamped power as it is for the next step.
                r_power    <= spe_clamp(w_scaled);
                r_exp_left <= r_exp_left - EXP_W'(1);
                if (spe_ovf(w_scaled)) begin
                    r_sat <= 1'b1;
                end
            end
            S_TERM: begin
                r_term <= spe_clamp(w_scaled);
                if (spe_ovf(w_scaled)) begin
                    r_sat <= 1'b1;
                end
            end
            S_ACC: begin
                r_sum <= spe_clamp(w_sum_wide);
                r_idx <= w_idx_next[IDX_W-1:0];
                if (w_last) begin
                    r_value  <= spe_clamp(w_sum_wide);
                    r_status <= (r_sat || spe_ovf(w_sum_wide)) ? ST_SAT : ST_DONE;
                end
                if (spe_ovf(w_sum_wide)) begin
                    r_sat <= 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    // Checks
    a_done_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !busy)
        else $error("result cycle not followed by idle");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_TERMS))
        else $error("term count exceeds table size");

    a_drop_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_rsp.status == ST_DROP) |-> w_full)
        else $error("drop reported with room in the table");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> busy)
        else $error("transfer did not raise busy");

    a_walk_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |-> (r_count != '0))
        else $error("term walk started on an empty table");

endmodule
